/* hdl/msh_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// msh_pkg
// Shared types and constants for the MIPS subset hazard/execute core.
// -----------------------------------------------------------------------------
package msh_pkg;

   localparam int OPCODE_W  = 3;
   localparam int REG_FLD_W = 5;
   localparam int DISP_W    = 16;
   localparam int VALUE_W   = 32;
   localparam int WSUM_W    = 15;  // signed word sum: base + disp/4
   localparam int STALL_W   = 2;

   localparam int DEF_NUM_REGS  = 32;
   localparam int DEF_MEM_WORDS = 32;

   localparam logic [STALL_W-1:0] STALL_NONE = 2'd0;
   localparam logic [STALL_W-1:0] STALL_ONE  = 2'd1;
   localparam logic [STALL_W-1:0] STALL_TWO  = 2'd2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_LW   = 3'd2,
      OP_SW   = 3'd3,
      OP_BEQ  = 3'd4,
      OP_NONE = 3'd7
   } op_type;

   // decoded instruction as held in the input stage
   typedef struct packed {
      op_type                     op;
      logic [REG_FLD_W-1:0]       dst;
      logic [REG_FLD_W-1:0]       ra;
      logic [REG_FLD_W-1:0]       rb;
      logic signed [WSUM_W-1:0]   wsum;
   } instr_type;

   // history entry for the hazard check
   typedef struct packed {
      op_type                     op;
      logic [REG_FLD_W-1:0]       wr_reg;
      logic signed [WSUM_W-1:0]   wsum;
   } hist_type;

endpackage

/* hdl/msh_rf.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// msh_rf
// Register file: one write port, two registered read ports with write bypass.
// -----------------------------------------------------------------------------
module msh_rf #(
   parameter int NUM_REGS = msh_pkg::DEF_NUM_REGS,
   parameter int RIDX_W   = $clog2(NUM_REGS)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [RIDX_W-1:0]            wr_addr,
   input  logic [msh_pkg::VALUE_W-1:0]  wr_data,
   input  logic                         rd_en,
   input  logic [RIDX_W-1:0]            rd_a_addr,
   input  logic [RIDX_W-1:0]            rd_b_addr,
   output logic [msh_pkg::VALUE_W-1:0]  rd_a_data,
   output logic [msh_pkg::VALUE_W-1:0]  rd_b_data
);

   logic [msh_pkg::VALUE_W-1:0] regs_ff [NUM_REGS];
   logic [msh_pkg::VALUE_W-1:0] rd_a_ff;
   logic [msh_pkg::VALUE_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         regs_ff[wr_addr] <= wr_data;
      end
   end

   // same-edge write wins over the stored word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_a_addr)) begin
            rd_a_ff <= wr_data;
         end else begin
            rd_a_ff <= regs_ff[rd_a_addr];
         end
         if (wr_en && (wr_addr == rd_b_addr)) begin
            rd_b_ff <= wr_data;
         end else begin
            rd_b_ff <= regs_ff[rd_b_addr];
         end
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

/* hdl/msh_dm.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// msh_dm
// Data memory: one write port, one registered read port with write bypass.
// -----------------------------------------------------------------------------
module msh_dm #(
   parameter int MEM_WORDS = msh_pkg::DEF_MEM_WORDS,
   parameter int MADDR_W   = $clog2(MEM_WORDS)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [MADDR_W-1:0]           wr_addr,
   input  logic [msh_pkg::VALUE_W-1:0]  wr_data,
   input  logic                         rd_en,
   input  logic [MADDR_W-1:0]           rd_addr,
   output logic [msh_pkg::VALUE_W-1:0]  rd_data
);

   logic [msh_pkg::VALUE_W-1:0] mem_ff [MEM_WORDS];
   logic [msh_pkg::VALUE_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_ff <= wr_data;
         end else begin
            rd_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_ff;

endmodule

/* hdl/msh_hz.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// msh_hz
// Hazard detection: bubble count from the current and last two instructions.
// -----------------------------------------------------------------------------
module msh_hz (
   input  msh_pkg::instr_type             cur,
   input  msh_pkg::hist_type              h1,
   input  msh_pkg::hist_type              h2,
   output logic [msh_pkg::STALL_W-1:0]    stall
);

   logic w1_vld;
   logic w2_vld;
   logic w1_hit_a;
   logic w1_hit_b;
   logic w2_hit;

   assign w1_vld = (h1.op == msh_pkg::OP_ADD) || (h1.op == msh_pkg::OP_SUB) ||
                   (h1.op == msh_pkg::OP_LW);
   assign w2_vld = (h2.op == msh_pkg::OP_ADD) || (h2.op == msh_pkg::OP_SUB) ||
                   (h2.op == msh_pkg::OP_LW);
   assign w1_hit_a = w1_vld && (h1.wr_reg == cur.ra);
   assign w1_hit_b = w1_vld && (h1.wr_reg == cur.rb);
   assign w2_hit   = w2_vld && ((h2.wr_reg == cur.ra) || (h2.wr_reg == cur.rb));

   always_comb begin
      stall = msh_pkg::STALL_NONE;
      unique case (cur.op)
         msh_pkg::OP_ADD, msh_pkg::OP_SUB: begin
            if (w1_hit_a || w1_hit_b) stall = msh_pkg::STALL_TWO;
         end
         msh_pkg::OP_LW: begin
            // load after store to the same word, compared before wrapping
            if (w1_vld) begin
               if (w1_hit_b) stall = msh_pkg::STALL_TWO;
            end else if ((h1.op == msh_pkg::OP_SW) && (h1.wsum == cur.wsum)) begin
               stall = msh_pkg::STALL_ONE;
            end
         end
         msh_pkg::OP_SW: begin
            if (w1_hit_a) stall = msh_pkg::STALL_TWO;
         end
         msh_pkg::OP_BEQ: begin
            if (w1_vld) begin
               if (w1_hit_a || w1_hit_b) begin
                  stall = msh_pkg::STALL_TWO;
               end else if (w2_hit) begin
                  stall = msh_pkg::STALL_ONE;
               end
            end
         end
         default: stall = msh_pkg::STALL_NONE;
      endcase
   end

endmodule

/* hdl/mips_subset_hazard_execute_core.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mips_subset_hazard_execute_core
// Executes add/sub/lw/sw/beq on a register file and data memory and reports
// hazard bubbles, branch outcome and register write-back per request.
// -----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   req     | in        | req_valid/req_ready  | opcode, regs, displacement
//   rsp     | out       | rsp_valid/rsp_ready  | stall, squash, branch, write-back
//
// One request per cycle sustained while rsp_ready is high. A request is accepted
// into the input stage, where the register file and data memory reads are
// registered; it is then executed into the response register once that is free.
// Same-edge write-back is bypassed into the reads, so back-to-back requests
// see each other's results. A stalled response holds the input stage, and
// req_ready drops only when both stages are full and rsp_ready is low.
// After reset an init sweep over max(NUM_REGS, MEM_WORDS) addresses loads the
// reset contents of both arrays; req_ready stays low during it.
// -----------------------------------------------------------------------------
module mips_subset_hazard_execute_core #(
   parameter int NUM_REGS  = msh_pkg::DEF_NUM_REGS,
   parameter int MEM_WORDS = msh_pkg::DEF_MEM_WORDS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [msh_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic [msh_pkg::REG_FLD_W-1:0]       req_dest_reg,
   input  logic [msh_pkg::REG_FLD_W-1:0]       req_first_reg,
   input  logic [msh_pkg::REG_FLD_W-1:0]       req_second_reg,
   input  logic signed [msh_pkg::DISP_W-1:0]   req_displacement,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [msh_pkg::STALL_W-1:0]         rsp_stall_cycles,
   output logic                                rsp_squashed,
   output logic                                rsp_branch_taken,
   output logic                                rsp_branch_not_taken,
   output logic                                rsp_reg_write_enable,
   output logic [msh_pkg::REG_FLD_W-1:0]       rsp_reg_write_index,
   output logic signed [msh_pkg::VALUE_W-1:0]  rsp_reg_write_value
);

   localparam int RIDX_W   = $clog2(NUM_REGS);
   localparam int MADDR_W  = $clog2(MEM_WORDS);
   localparam int NREG_FLD = 2 ** msh_pkg::REG_FLD_W;
   localparam int VW       = msh_pkg::VALUE_W;
   localparam int WW       = msh_pkg::WSUM_W;

   // word index = (wsum mod MEM_WORDS): bias to non-negative, then
   // reciprocal multiply with a single correction step
   localparam int MIN_WSUM   = 2 ** (msh_pkg::DISP_W - 3);
   localparam int MEM_OFS    = ((MIN_WSUM + MEM_WORDS - 1) / MEM_WORDS) * MEM_WORDS;
   localparam int RECIP_SH   = 24;
   localparam int MEM_RECIP  = (2 ** RECIP_SH) / MEM_WORDS;
   localparam int PROD_W     = WW + RECIP_SH;
   localparam int QM_W       = WW + MADDR_W + 1;
   localparam int REM_W      = MADDR_W + 2;

   localparam int CLR_N  = (NUM_REGS > MEM_WORDS) ? NUM_REGS : MEM_WORDS;
   localparam int CLR_W  = $clog2(CLR_N);
   localparam int CLR_CW = CLR_W + 1;  // room to hold the array depths

   // squash tracking
   localparam logic [1:0] SQ_IDLE   = 2'd0;
   localparam logic [1:0] SQ_NOSTL  = 2'd1;  // zero-stall mode
   localparam logic [1:0] SQ_FLUSH  = 2'd2;  // flush next request

   // ---------------- register index table (field mod NUM_REGS) -------------
   logic [RIDX_W-1:0] reg_map [NREG_FLD];
   for (genvar g = 0; g < NREG_FLD; g++) begin : g_reg_map
      assign reg_map[g] = RIDX_W'(g % NUM_REGS);
   end

   // ---------------- request decode ----------------------------------------
   msh_pkg::instr_type            req_instr;
   logic signed [msh_pkg::DISP_W:0] disp_adj;
   logic signed [WW-1:0]          disp_q4;
   logic [WW-1:0]                 mem_u;
   logic [PROD_W-1:0]             mem_prod;
   logic [WW-1:0]                 mem_q;
   logic [QM_W-1:0]               mem_qm;
   logic [REM_W-1:0]              mem_r;
   logic [MADDR_W-1:0]            req_midx;

   // divide by four truncating toward zero
   assign disp_adj = {req_displacement[msh_pkg::DISP_W-1], req_displacement} +
                     (req_displacement[msh_pkg::DISP_W-1] ? 17'sd3 : 17'sd0);
   assign disp_q4  = disp_adj[msh_pkg::DISP_W:2];

   always_comb begin
      req_instr.op   = (req_opcode > msh_pkg::OP_BEQ) ? msh_pkg::OP_NONE
                                                     : msh_pkg::op_type'(req_opcode);
      req_instr.dst  = req_dest_reg;
      req_instr.ra   = req_first_reg;
      req_instr.rb   = req_second_reg;
      req_instr.wsum = disp_q4 + $signed({{(WW - msh_pkg::REG_FLD_W){1'b0}},
                                         req_second_reg});
   end

   assign mem_u    = $unsigned(req_instr.wsum) + WW'(MEM_OFS);
   assign mem_prod = PROD_W'(mem_u) * PROD_W'(MEM_RECIP);
   assign mem_q    = mem_prod[PROD_W-1:RECIP_SH];
   assign mem_qm   = QM_W'(mem_q) * QM_W'(MEM_WORDS);
   assign mem_r    = REM_W'(mem_u) - mem_qm[REM_W-1:0];
   assign req_midx = (mem_r >= REM_W'(MEM_WORDS)) ? MADDR_W'(mem_r - REM_W'(MEM_WORDS))
                                                  : mem_r[MADDR_W-1:0];

   // ---------------- control ----------------------------------------------
   logic                 clr_busy_ff;
   logic [CLR_W-1:0]     clr_cnt_ff;
   logic                 a_valid_ff;
   msh_pkg::instr_type   a_instr_ff;
   logic [MADDR_W-1:0]   a_midx_ff;
   msh_pkg::hist_type    h1_ff;
   msh_pkg::hist_type    h2_ff;
   logic [1:0]           sq_ff;
   logic [1:0]           sq_in;
   logic                 rsp_valid_ff;

   logic req_acc;
   logic adv;

   assign adv       = a_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clr_busy_ff && (!a_valid_ff || adv);
   assign req_acc   = req_valid && req_ready;

   // ---------------- arrays -------------------------------------------------
   logic [VW-1:0]        rd_a;
   logic [VW-1:0]        rd_b;
   logic [VW-1:0]        mem_rd;
   logic                 rf_we;
   logic [RIDX_W-1:0]    rf_waddr;
   logic [VW-1:0]        rf_wdata;
   logic                 dm_we;
   logic [MADDR_W-1:0]   dm_waddr;
   logic [VW-1:0]        dm_wdata;

   msh_rf #(
      .NUM_REGS (NUM_REGS),
      .RIDX_W   (RIDX_W)
   ) u_rf (
      .clock     (clock),
      .wr_en     (rf_we),
      .wr_addr   (rf_waddr),
      .wr_data   (rf_wdata),
      .rd_en     (req_acc),
      .rd_a_addr (reg_map[req_first_reg]),
      .rd_b_addr (reg_map[req_second_reg]),
      .rd_a_data (rd_a),
      .rd_b_data (rd_b)
   );

   msh_dm #(
      .MEM_WORDS (MEM_WORDS),
      .MADDR_W   (MADDR_W)
   ) u_dm (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_en   (req_acc),
      .rd_addr (req_midx),
      .rd_data (mem_rd)
   );

   // ---------------- hazard ------------------------------------------------
   logic [msh_pkg::STALL_W-1:0] hz_stall;

   msh_hz u_hz (
      .cur   (a_instr_ff),
      .h1    (h1_ff),
      .h2    (h2_ff),
      .stall (hz_stall)
   );

   // ---------------- execute ------------------------------------------------
   logic                          ex_flush;
   logic [msh_pkg::STALL_W-1:0]   ex_stall;
   logic                          ex_bt;
   logic                          ex_bnt;
   logic                          ex_we;
   logic [msh_pkg::REG_FLD_W-1:0] ex_widx;
   logic [VW-1:0]                 ex_wval;
   logic                          ex_sw;
   msh_pkg::hist_type             ex_hist;

   assign ex_flush = (sq_ff == SQ_FLUSH);

   always_comb begin
      ex_stall = msh_pkg::STALL_NONE;
      ex_bt    = 1'b0;
      ex_bnt   = 1'b0;
      ex_we    = 1'b0;
      ex_widx  = '0;
      ex_wval  = '0;
      ex_sw    = 1'b0;
      sq_in    = sq_ff;
      if (ex_flush) begin
         sq_in = SQ_NOSTL;
      end else begin
         if (sq_ff == SQ_IDLE) ex_stall = hz_stall;
         unique case (a_instr_ff.op)
            msh_pkg::OP_ADD: begin
               ex_we   = 1'b1;
               ex_widx = a_instr_ff.dst;
               ex_wval = rd_a + rd_b;
               sq_in   = SQ_IDLE;
            end
            msh_pkg::OP_SUB: begin
               ex_we   = 1'b1;
               ex_widx = a_instr_ff.dst;
               ex_wval = rd_a - rd_b;
               sq_in   = SQ_IDLE;
            end
            msh_pkg::OP_LW: begin
               ex_we   = 1'b1;
               ex_widx = a_instr_ff.ra;
               ex_wval = mem_rd;
               sq_in   = SQ_IDLE;
            end
            msh_pkg::OP_SW: begin
               ex_sw = 1'b1;
               sq_in = SQ_IDLE;
            end
            msh_pkg::OP_BEQ: begin
               if (rd_a == rd_b) begin
                  ex_bt = 1'b1;
                  sq_in = SQ_FLUSH;
               end else begin
                  ex_bnt = 1'b1;
               end
            end
            default: sq_in = sq_ff;
         endcase
      end
   end

   always_comb begin
      ex_hist.op     = a_instr_ff.op;
      ex_hist.wr_reg = (a_instr_ff.op == msh_pkg::OP_LW) ? a_instr_ff.ra : a_instr_ff.dst;
      ex_hist.wsum   = a_instr_ff.wsum;
   end

   // write ports: init sweep, else write-back of the retiring request
   always_comb begin
      if (clr_busy_ff) begin
         rf_we    = ({1'b0, clr_cnt_ff} < CLR_CW'(NUM_REGS));
         rf_waddr = RIDX_W'(clr_cnt_ff);
         rf_wdata = (clr_cnt_ff == '0) ? '0 : VW'(1);
         dm_we    = ({1'b0, clr_cnt_ff} < CLR_CW'(MEM_WORDS));
         dm_waddr = MADDR_W'(clr_cnt_ff);
         dm_wdata = VW'(1);
      end else begin
         rf_we    = adv && ex_we;
         rf_waddr = reg_map[ex_widx];
         rf_wdata = ex_wval;
         dm_we    = adv && ex_sw;
         dm_waddr = a_midx_ff;
         dm_wdata = rd_a;
      end
   end

   // ---------------- registers ---------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         if (clr_cnt_ff == CLR_W'(CLR_N - 1)) begin
            clr_busy_ff <= 1'b0;
         end
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_acc) begin
         a_valid_ff <= 1'b1;
      end else if (adv) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_instr_ff <= req_instr;
         a_midx_ff  <= req_midx;
      end
   end

   // history and squash state move when a request retires
   always_ff @(posedge clock) begin
      if (reset) begin
         h1_ff    <= '{op: msh_pkg::OP_NONE, wr_reg: '0, wsum: '0};
         h2_ff    <= '{op: msh_pkg::OP_NONE, wr_reg: '0, wsum: '0};
         sq_ff    <= SQ_IDLE;
      end else if (adv) begin
         h2_ff <= h1_ff;
         h1_ff <= ex_hist;
         sq_ff <= sq_in;
      end
   end

   // response register
   logic [msh_pkg::STALL_W-1:0]   stall_ff;
   logic                          squashed_ff;
   logic                          bt_ff;
   logic                          bnt_ff;
   logic                          we_ff;
   logic [msh_pkg::REG_FLD_W-1:0] widx_ff;
   logic [VW-1:0]                 wval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stall_ff    <= ex_stall;
         squashed_ff <= ex_flush;
         bt_ff       <= ex_bt;
         bnt_ff      <= ex_bnt;
         we_ff       <= ex_we;
         widx_ff     <= ex_widx;
         wval_ff     <= ex_wval;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_stall_cycles     = stall_ff;
   assign rsp_squashed         = squashed_ff;
   assign rsp_branch_taken     = bt_ff;
   assign rsp_branch_not_taken = bnt_ff;
   assign rsp_reg_write_enable = we_ff;
   assign rsp_reg_write_index  = widx_ff;
   assign rsp_reg_write_value  = $signed(wval_ff);

endmodule

/* sim/mips_subset_hazard_execute_core_tb.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mips_subset_hazard_execute_core_tb
// Self-checking bench for the add/sub/lw/sw/beq execute core with hazard
// detection. A directed table covers the extremes and every hazard and squash
// case; random instruction streams with a small register pool follow, under
// three idle profiles. A cycle-free predictor with its own register file,
// data memory, history and squash mode computes each expected response.
// -----------------------------------------------------------------------------
module mips_subset_hazard_execute_core_tb;

   import msh_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 8;
   localparam int RAND_PER_PHASE = 442;
   localparam int HOLD_CYCLES    = 60;
   localparam int DRAIN_CYCLES   = 10;
   localparam int TIMEOUT_NS     = 2_000_000;
   localparam int DIR_ROWS       = 25;
   localparam int REG_COUNT      = DEF_NUM_REGS;
   localparam int WORD_COUNT     = DEF_MEM_WORDS;

   // reserved opcodes have no name in the package; they decode as no-op
   localparam logic [OPCODE_W-1:0] OPC_RSV5 = 3'd5;
   localparam logic [OPCODE_W-1:0] OPC_RSV6 = 3'd6;

   // squash tracking: idle, quiet (no stalls reported), flush next request
   typedef enum logic [1:0] {
      SQ_IDLE  = 2'd0,
      SQ_QUIET = 2'd1,
      SQ_FLUSH = 2'd2
   } squash_mode_t;

   typedef struct packed {
      logic [STALL_W-1:0]   stall;
      logic                 squashed;
      logic                 taken;
      logic                 not_taken;
      logic                 we;
      logic [REG_FLD_W-1:0] widx;
      logic [VALUE_W-1:0]   wval;
   } outcome_t;

   typedef struct {
      op_type                    op;
      logic [REG_FLD_W-1:0]      dst;
      logic [REG_FLD_W-1:0]      ra;
      logic [REG_FLD_W-1:0]      rb;
      logic signed [DISP_W-1:0]  disp;
   } insn_t;

   // one directed request; want is used only where typed is set
   typedef struct packed {
      logic [OPCODE_W-1:0]  opc;
      logic [REG_FLD_W-1:0] rd;
      logic [REG_FLD_W-1:0] ra;
      logic [REG_FLD_W-1:0] rb;
      logic [DISP_W-1:0]    disp;
      logic                 typed;
      outcome_t             want;
   } dir_row_t;

   localparam outcome_t QUIET_OUTCOME  = '0;
   localparam outcome_t SQUASH_OUTCOME = '{STALL_NONE, 1'b1, 1'b0, 1'b0, 1'b0, 5'd0, 32'd0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid        = 1'b0;
   logic                        req_ready;
   logic [OPCODE_W-1:0]         req_opcode       = '0;
   logic [REG_FLD_W-1:0]        req_dest_reg     = '0;
   logic [REG_FLD_W-1:0]        req_first_reg    = '0;
   logic [REG_FLD_W-1:0]        req_second_reg   = '0;
   logic signed [DISP_W-1:0]    req_displacement = '0;
   logic                        rsp_valid;
   logic                        rsp_ready        = 1'b0;
   logic [STALL_W-1:0]          rsp_stall_cycles;
   logic                        rsp_squashed;
   logic                        rsp_branch_taken;
   logic                        rsp_branch_not_taken;
   logic                        rsp_reg_write_enable;
   logic [REG_FLD_W-1:0]        rsp_reg_write_index;
   logic signed [VALUE_W-1:0]   rsp_reg_write_value;

   mips_subset_hazard_execute_core uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_dest_reg         (req_dest_reg),
      .req_first_reg        (req_first_reg),
      .req_second_reg       (req_second_reg),
      .req_displacement     (req_displacement),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_stall_cycles     (rsp_stall_cycles),
      .rsp_squashed         (rsp_squashed),
      .rsp_branch_taken     (rsp_branch_taken),
      .rsp_branch_not_taken (rsp_branch_not_taken),
      .rsp_reg_write_enable (rsp_reg_write_enable),
      .rsp_reg_write_index  (rsp_reg_write_index),
      .rsp_reg_write_value  (rsp_reg_write_value)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor state: architectural copy of the core, updated per accepted
   // request in acceptance order.
   // ---------------------------------------------------------------------------
   logic [VALUE_W-1:0] gpr_model [REG_COUNT];
   logic [VALUE_W-1:0] mem_model [WORD_COUNT];
   insn_t              prev_1;
   insn_t              prev_2;
   squash_mode_t       squash_mode;

   outcome_t pending_outcomes [$];
   int       errors = 0;

   // idle profile; receiver's share is written with NBAs from the stimulus side
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;

   // long receiver hold-off, requested by stimulus and timed by the receiver
   int hold_asked = 0;
   int hold_seen  = 0;
   int hold_left  = 0;

   // random stream memory: last written register and last store address
   logic [REG_FLD_W-1:0] gen_last_dst  = '0;
   logic [REG_FLD_W-1:0] last_sw_base  = '0;
   logic [DISP_W-1:0]    last_sw_disp  = '0;

   // Directed rows. Typed rows are easy to read off the reset state:
   // r0 = 0, other registers and all memory words = 1.
   dir_row_t dir_tbl [DIR_ROWS] = '{
      // plain add, then sub wrapping below zero
      '{OP_ADD, 5'd3, 5'd1, 5'd2, 16'h0000, 1'b1,
        '{STALL_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 5'd3, 32'd2}},
      '{OP_SUB, 5'd4, 5'd0, 5'd1, 16'h0000, 1'b1,
        '{STALL_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 5'd4, 32'hFFFF_FFFF}},
      // back-to-back RAW on both sources
      '{OP_ADD, 5'd5, 5'd4, 5'd4, 16'h0000, 1'b1,
        '{STALL_TWO, 1'b0, 1'b0, 1'b0, 1'b1, 5'd5, 32'hFFFF_FFFE}},
      // largest offset, top base register, address wraps to word 30
      '{OP_LW, 5'd0, 5'd6, 5'd31, 16'h7FFF, 1'b1,
        '{STALL_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 5'd6, 32'd1}},
      // most negative offset, negative word sum wraps to word 0
      '{OP_SW, 5'd0, 5'd5, 5'd0, 16'h8000, 1'b1, QUIET_OUTCOME},
      // load right after store to the same word
      '{OP_LW, 5'd0, 5'd7, 5'd0, 16'h8000, 1'b1,
        '{STALL_ONE, 1'b0, 1'b0, 1'b0, 1'b1, 5'd7, 32'hFFFF_FFFE}},
      '{OP_SW, 5'd0, 5'd1, 5'd0, 16'h0000, 1'b1, QUIET_OUTCOME},
      // same wrapped word, different unwrapped sum: no store-load bubble
      '{OP_LW, 5'd0, 5'd8, 5'd0, 16'h0080, 1'b0, QUIET_OUTCOME},
      // taken branch, next request squashed, then quiet mode masks a RAW
      '{OP_BEQ, 5'd0, 5'd1, 5'd2, 16'h7FFF, 1'b0, QUIET_OUTCOME},
      '{OP_ADD, 5'd1, 5'd1, 5'd1, 16'h0000, 1'b1, SQUASH_OUTCOME},
      '{OP_ADD, 5'd10, 5'd1, 5'd1, 16'h0000, 1'b1,
        '{STALL_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 5'd10, 32'd2}},
      // beq reading a register written two back; not taken
      '{OP_ADD, 5'd11, 5'd3, 5'd0, 16'h0000, 1'b0, QUIET_OUTCOME},
      '{OP_SUB, 5'd12, 5'd2, 5'd2, 16'h0000, 1'b0, QUIET_OUTCOME},
      '{OP_BEQ, 5'd0, 5'd11, 5'd1, 16'h8000, 1'b0, QUIET_OUTCOME},
      // beq after beq, taken; the no-op behind it is squashed
      '{OP_BEQ, 5'd0, 5'd12, 5'd0, 16'hFFFF, 1'b0, QUIET_OUTCOME},
      '{OP_NONE, 5'd31, 5'd31, 5'd31, 16'hFFFF, 1'b1, SQUASH_OUTCOME},
      // not-taken beq and a reserved opcode both keep quiet mode
      '{OP_BEQ, 5'd0, 5'd0, 5'd1, 16'h0000, 1'b0, QUIET_OUTCOME},
      '{OPC_RSV5, 5'd0, 5'd0, 5'd0, 16'h0000, 1'b1, QUIET_OUTCOME},
      // write to r0 with wrap-around; clears quiet mode
      '{OP_ADD, 5'd0, 5'd4, 5'd4, 16'hFFFF, 1'b1,
        '{STALL_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 5'd0, 32'hFFFF_FFFE}},
      '{OP_SW, 5'd0, 5'd0, 5'd31, 16'h0004, 1'b1,
        '{STALL_TWO, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 32'd0}},
      '{OP_LW, 5'd0, 5'd31, 5'd31, 16'h0004, 1'b0, QUIET_OUTCOME},
      // load-use on the base, unaligned negative offset
      '{OP_LW, 5'd0, 5'd9, 5'd31, 16'hFFFD, 1'b0, QUIET_OUTCOME},
      '{OP_BEQ, 5'd0, 5'd9, 5'd9, 16'h0000, 1'b0, QUIET_OUTCOME},
      '{OPC_RSV6, 5'd0, 5'd0, 5'd0, 16'h0000, 1'b0, QUIET_OUTCOME},
      '{OP_SW, 5'd0, 5'd0, 5'd0, 16'hFFFC, 1'b0, QUIET_OUTCOME}
   };

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------
   function automatic void reset_model();
      for (int k = 0; k < REG_COUNT; k++) gpr_model[k] = (k == 0) ? '0 : 32'd1;
      for (int k = 0; k < WORD_COUNT; k++) mem_model[k] = 32'd1;
      prev_1      = '{OP_NONE, '0, '0, '0, '0};
      prev_2      = '{OP_NONE, '0, '0, '0, '0};
      squash_mode = SQ_IDLE;
   endfunction

   // destination of an older instruction, -1 when it writes nothing
   function automatic int written_reg(insn_t p);
      if (p.op == OP_ADD || p.op == OP_SUB) return int'(p.dst);
      if (p.op == OP_LW) return int'(p.ra);
      return -1;
   endfunction

   // unwrapped word address; division truncates toward zero
   function automatic int word_sum(insn_t x);
      return int'(x.rb) + int'(x.disp) / 4;
   endfunction

   function automatic int mem_word(insn_t x);
      int s;
      s = word_sum(x) % WORD_COUNT;
      if (s < 0) s += WORD_COUNT;
      return s;
   endfunction

   function automatic logic [STALL_W-1:0] bubble_count(insn_t c);
      int w1;
      int w2;
      int a;
      int b;
      w1 = written_reg(prev_1);
      a  = int'(c.ra);
      b  = int'(c.rb);
      case (c.op)
         OP_ADD, OP_SUB: begin
            return (w1 >= 0 && (w1 == a || w1 == b)) ? STALL_TWO : STALL_NONE;
         end
         OP_LW: begin
            if (w1 >= 0) return (w1 == b) ? STALL_TWO : STALL_NONE;
            // store then load, compared on the unwrapped sum
            if (prev_1.op == OP_SW && word_sum(prev_1) == word_sum(c)) return STALL_ONE;
            return STALL_NONE;
         end
         OP_SW: begin
            return (w1 >= 0 && w1 == a) ? STALL_TWO : STALL_NONE;
         end
         OP_BEQ: begin
            if (w1 < 0) return STALL_NONE;
            if (w1 == a || w1 == b) return STALL_TWO;
            w2 = written_reg(prev_2);
            return (w2 >= 0 && (w2 == a || w2 == b)) ? STALL_ONE : STALL_NONE;
         end
         default: begin
            return STALL_NONE;
         end
      endcase
   endfunction

   // executes one request on the model and returns its response
   function automatic outcome_t execute_instr(
      input logic [OPCODE_W-1:0]  opc,
      input logic [REG_FLD_W-1:0] rd,
      input logic [REG_FLD_W-1:0] ra,
      input logic [REG_FLD_W-1:0] rb,
      input logic [DISP_W-1:0]    disp
   );
      insn_t              c;
      outcome_t           o;
      logic [VALUE_W-1:0] x;
      logic [VALUE_W-1:0] y;
      c.op   = (opc > 3'(OP_BEQ)) ? OP_NONE : op_type'(opc);
      c.dst  = rd;
      c.ra   = ra;
      c.rb   = rb;
      c.disp = disp;
      o      = '0;
      if (squash_mode == SQ_FLUSH) begin
         // flushed: not executed, but still enters the history
         o.squashed  = 1'b1;
         squash_mode = SQ_QUIET;
      end else begin
         o.stall = (squash_mode != SQ_IDLE) ? STALL_NONE : bubble_count(c);
         case (c.op)
            OP_ADD, OP_SUB: begin
               x      = gpr_model[c.ra];
               y      = gpr_model[c.rb];
               o.wval = (c.op == OP_ADD) ? x + y : x - y;
               o.we   = 1'b1;
               o.widx = c.dst;
               gpr_model[c.dst] = o.wval;
               squash_mode = SQ_IDLE;
            end
            OP_LW: begin
               o.wval = mem_model[mem_word(c)];
               o.we   = 1'b1;
               o.widx = c.ra;
               gpr_model[c.ra] = o.wval;
               squash_mode = SQ_IDLE;
            end
            OP_SW: begin
               mem_model[mem_word(c)] = gpr_model[c.ra];
               squash_mode = SQ_IDLE;
            end
            OP_BEQ: begin
               if (gpr_model[c.ra] == gpr_model[c.rb]) begin
                  o.taken     = 1'b1;
                  squash_mode = SQ_FLUSH;
               end else begin
                  o.not_taken = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      prev_2 = prev_1;
      prev_1 = c;
      return o;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------

   // Presents one request after a random idle gap and waits for acceptance.
   // req_valid gets a single NBA per time step: lowered only inside the gap.
   task automatic send_request(
      input logic [OPCODE_W-1:0]  opc,
      input logic [REG_FLD_W-1:0] rd,
      input logic [REG_FLD_W-1:0] ra,
      input logic [REG_FLD_W-1:0] rb,
      input logic [DISP_W-1:0]    disp,
      input logic                 typed,
      input outcome_t             want
   );
      outcome_t pred;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= opc;
      req_dest_reg     <= rd;
      req_first_reg    <= ra;
      req_second_reg   <= rb;
      req_displacement <= disp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = execute_instr(opc, rd, ra, rb, disp);
      pending_outcomes.push_back(typed ? want : pred);
   endtask

   // mostly a small register pool so hazards and equal beq operands are common
   function automatic logic [REG_FLD_W-1:0] pick_reg();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 5'($urandom_range(3));
      if (r < 80) return gen_last_dst;
      return 5'($urandom_range(31));
   endfunction

   task automatic draw_request(
      output logic [OPCODE_W-1:0]  opc,
      output logic [REG_FLD_W-1:0] rd,
      output logic [REG_FLD_W-1:0] ra,
      output logic [REG_FLD_W-1:0] rb,
      output logic [DISP_W-1:0]    disp
   );
      int sel;
      sel = $urandom_range(99);
      if (sel < 20)      opc = OP_ADD;
      else if (sel < 35) opc = OP_SUB;
      else if (sel < 55) opc = OP_LW;
      else if (sel < 73) opc = OP_SW;
      else if (sel < 95) opc = OP_BEQ;
      else               opc = 3'($urandom_range(OPC_RSV5, OP_NONE));
      rd  = pick_reg();
      ra  = pick_reg();
      rb  = pick_reg();
      sel = $urandom_range(99);
      if (sel < 40)      disp = 16'(4 * int'($urandom_range(15)) - 32);
      else if (sel < 60) disp = 16'(int'($urandom_range(16)) - 8);
      else if (sel < 88) disp = 16'($urandom);
      else               disp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      // load from the word just stored to
      if (opc == OP_LW && $urandom_range(99) < 35) begin
         rb   = last_sw_base;
         disp = last_sw_disp;
      end
      case (opc)
         OP_ADD, OP_SUB: gen_last_dst = rd;
         OP_LW:          gen_last_dst = ra;
         OP_SW: begin
            last_sw_base = rb;
            last_sw_disp = disp;
         end
         default: begin
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence: reset, directed table, three random phases, drain.
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      logic [OPCODE_W-1:0]  opc;
      logic [REG_FLD_W-1:0] rd;
      logic [REG_FLD_W-1:0] ra;
      logic [REG_FLD_W-1:0] rb;
      logic [DISP_W-1:0]    disp;
      reset_model();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // req_ready stays low through the init sweep; the handshake absorbs it
      snd_idle_pct = 14;
      rcv_idle_pct <= 79;
      foreach (dir_tbl[i]) begin
         send_request(dir_tbl[i].opc, dir_tbl[i].rd, dir_tbl[i].ra, dir_tbl[i].rb,
                      dir_tbl[i].disp, dir_tbl[i].typed, dir_tbl[i].want);
      end
      for (int phase = 0; phase < 3; phase++) begin
         // sender pauses until every outstanding request has come back
         req_valid <= 1'b0;
         while (pending_outcomes.size() != 0) @(posedge clock);
         case (phase)
            0: begin
               snd_idle_pct = 14;
               rcv_idle_pct <= 79;
            end
            1: begin
               snd_idle_pct = 79;
               rcv_idle_pct <= 14;
            end
            default: begin
               snd_idle_pct = 0;
               rcv_idle_pct <= 0;
            end
         endcase
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            // back-pressure burst: receiver blocks while requests keep coming
            if (phase == 2 && n == 100) hold_asked <= hold_asked + 1;
            draw_request(opc, rd, ra, rb, disp);
            send_request(opc, rd, ra, rb, disp, 1'b0, QUIET_OUTCOME);
         end
      end
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      // catch any stray response after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Response side: random ready, plus the long hold-off when asked.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   task automatic field_mismatch(input string fname, input logic [VALUE_W-1:0] want,
                                 input logic [VALUE_W-1:0] got);
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
      errors++;
   endtask

   // compare each accepted response with the oldest expected one
   always @(posedge clock) begin : rsp_check
      outcome_t got;
      outcome_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_stall_cycles, rsp_squashed, rsp_branch_taken, rsp_branch_not_taken,
                 rsp_reg_write_enable, rsp_reg_write_index, rsp_reg_write_value};
         if (pending_outcomes.size() == 0) begin
            $display("%0t: response with none expected, actual 0x%0h", $time, got);
            errors++;
         end else begin
            want = pending_outcomes.pop_front();
            if (got.stall !== want.stall)
               field_mismatch("stall_cycles", want.stall, got.stall);
            if (got.squashed !== want.squashed)
               field_mismatch("squashed", want.squashed, got.squashed);
            if (got.taken !== want.taken)
               field_mismatch("branch_taken", want.taken, got.taken);
            if (got.not_taken !== want.not_taken)
               field_mismatch("branch_not_taken", want.not_taken, got.not_taken);
            if (got.we !== want.we)
               field_mismatch("reg_write_enable", want.we, got.we);
            if (got.widx !== want.widx)
               field_mismatch("reg_write_index", want.widx, got.widx);
            if (got.wval !== want.wval)
               field_mismatch("reg_write_value", want.wval, got.wval);
         end
      end
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* sim.f */
hdl/msh_pkg.sv
hdl/msh_rf.sv
hdl/msh_dm.sv
hdl/msh_hz.sv
hdl/mips_subset_hazard_execute_core.sv
sim/mips_subset_hazard_execute_core_tb.sv
